### src/dpcm_pkg.sv
// Shared types and constants for the DPCM image encoder.
// No dependencies; compile first.
`default_nettype none

package dpcm_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_W = 11;

  localparam logic [PIX_W-1:0] MID_GREY = 8'd128;

  // configuration register indexes
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_STEP  = 2'd1;
  localparam logic [1:0] REG_WIDTH = 2'd2;

  // predictor codes, shared by the mode register and the predictor_used field
  localparam logic [1:0] PRED_LEFT    = 2'd0;
  localparam logic [1:0] PRED_MEAN    = 2'd1;
  localparam logic [1:0] PRED_ADAPT   = 2'd2;
  localparam logic [1:0] PRED_COMPETE = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRED,
    ST_DIV,
    ST_DONE
  } enc_state_t;

  typedef struct packed {
    logic [PIX_W-1:0] pred;
    logic [PIX_W-1:0] biased;
    logic [1:0]       sel;
  } pred_res_t;

endpackage

`default_nettype wire

### src/dpcm_if.sv
// Valid/ready channel interfaces for pixel words and result words.
// Depends on nothing but the package widths.
`default_nettype none

interface dpcm_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [dpcm_pkg::PIX_W-1:0] pixel;
  logic                      frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface dpcm_result_if;
  logic                      valid;
  logic                      ready;
  logic [dpcm_pkg::PIX_W-1:0] biased_error;
  logic [dpcm_pkg::PIX_W-1:0] code;
  logic [dpcm_pkg::PIX_W-1:0] recon_pixel;
  logic [1:0]                predictor_used;

  modport source (output valid, output biased_error, output code, output recon_pixel,
                  output predictor_used, input ready);
  modport sink (input valid, input biased_error, input code, input recon_pixel,
                input predictor_used, output ready);
endinterface

`default_nettype wire

### src/dpcm_line_store.sv
// Line store holding the reconstructed previous row; registered read.
// Depends on dpcm_pkg.
`default_nettype none

module dpcm_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [dpcm_pkg::PIX_W-1:0] rd_data,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [dpcm_pkg::PIX_W-1:0] wr_data
);

  logic [dpcm_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### src/dpcm_predictor.sv
// Forms left, mean and adaptive predictions and selects one by mode or by least error.
// Depends on dpcm_pkg.
`default_nettype none

module dpcm_predictor (
  input  wire logic [dpcm_pkg::PIX_W-1:0] pixel,
  input  wire logic [dpcm_pkg::PIX_W-1:0] a,
  input  wire logic [dpcm_pkg::PIX_W-1:0] b,
  input  wire logic [dpcm_pkg::PIX_W-1:0] c,
  input  wire logic [1:0]                 mode,
  output dpcm_pkg::pred_res_t             res
);

  logic [dpcm_pkg::PIX_W:0]   sum_ac;
  logic [dpcm_pkg::PIX_W-1:0] p_left, p_mean, p_adapt;
  logic [dpcm_pkg::PIX_W-1:0] d_cb, d_ab;
  logic [dpcm_pkg::PIX_W-1:0] e_left, e_mean, e_adapt;
  logic [dpcm_pkg::PIX_W-1:0] best_err;
  logic [1:0]                 sel;

  always_comb begin
    sum_ac  = {1'b0, a} + {1'b0, c};
    p_left  = a;
    p_mean  = sum_ac[dpcm_pkg::PIX_W:1];
    d_cb    = (c > b) ? (c - b) : (b - c);
    d_ab    = (a > b) ? (a - b) : (b - a);
    p_adapt = (d_cb < d_ab) ? a : c;
    // mod 256 wrap is free at byte width
    e_left  = pixel - p_left + dpcm_pkg::MID_GREY;
    e_mean  = pixel - p_mean + dpcm_pkg::MID_GREY;
    e_adapt = pixel - p_adapt + dpcm_pkg::MID_GREY;

    // earliest predictor wins ties
    sel      = dpcm_pkg::PRED_LEFT;
    best_err = e_left;
    if (e_mean < best_err) begin
      sel      = dpcm_pkg::PRED_MEAN;
      best_err = e_mean;
    end
    if (e_adapt < best_err) begin
      sel = dpcm_pkg::PRED_ADAPT;
    end
    if (mode != dpcm_pkg::PRED_COMPETE) begin
      sel = mode;
    end

    unique case (sel)
      dpcm_pkg::PRED_LEFT: begin
        res.pred   = p_left;
        res.biased = e_left;
      end
      dpcm_pkg::PRED_MEAN: begin
        res.pred   = p_mean;
        res.biased = e_mean;
      end
      default: begin
        res.pred   = p_adapt;
        res.biased = e_adapt;
      end
    endcase
    res.sel = sel;
  end

endmodule

`default_nettype wire

### src/dpcm_rem_serial.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on dpcm_pkg.
`default_nettype none

module dpcm_rem_serial (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [dpcm_pkg::PIX_W-1:0] dividend,
  input  wire logic [dpcm_pkg::PIX_W-1:0] divisor,
  output logic                            done,
  output logic      [dpcm_pkg::PIX_W-1:0] rem
);

  localparam int CNT_W = $clog2(dpcm_pkg::PIX_W);

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [dpcm_pkg::PIX_W-1:0] dvd;
  logic [dpcm_pkg::PIX_W-1:0] dsr;
  logic [dpcm_pkg::PIX_W:0]   trial;
  logic [dpcm_pkg::PIX_W-1:0] rem_next;

  always_comb begin
    trial = {rem, dvd[dpcm_pkg::PIX_W-1]};
    if (trial >= {1'b0, dsr}) begin
      rem_next = dpcm_pkg::PIX_W'(trial - {1'b0, dsr});
    end else begin
      rem_next = trial[dpcm_pkg::PIX_W-1:0];
    end
  end

  assign done = busy && (cnt == CNT_W'(dpcm_pkg::PIX_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[dpcm_pkg::PIX_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire

### src/dpcm_image_encoder.sv
// Top level of the closed-loop DPCM encoder: control FSM, neighbor state, quantizer.
// Depends on dpcm_pkg, dpcm_if, dpcm_line_store, dpcm_predictor, dpcm_rem_serial.
//
//   channel   dir  words                                         handshake
//   pixels    in   pixel, frame_start                            valid/ready
//   results   out  biased_error, code, recon_pixel, predictor_used  valid/ready
//   cfg_*     in   index, data (mode, step, width)               write enable
//
// Each pixel passes through accept with line store read, prediction,
// the bit-serial remainder unit, then quantize and write back.
// The next pixel is taken in the cycle after write-back, even while the
// previous result word still waits in the output register.
// A full output register stalls write-back. Reset is synchronous; the line
// store is not cleared and holds nothing meaningful until a row is written.
`default_nettype none

module dpcm_image_encoder #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [dpcm_pkg::CFG_W-1:0] cfg_data,
  dpcm_pixel_if.sink                      pixels,
  dpcm_result_if.source                   results
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int LW = (CW + 1 > dpcm_pkg::CFG_W) ? CW + 1 : dpcm_pkg::CFG_W;
  localparam int PW = dpcm_pkg::PIX_W;

  // configuration
  logic [1:0]                 predictor_mode;
  logic [PW-1:0]              quant_step;
  logic [dpcm_pkg::CFG_W-1:0] image_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      predictor_mode <= dpcm_pkg::PRED_LEFT;
      quant_step     <= '0;
      image_width    <= dpcm_pkg::CFG_W'(512);
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpcm_pkg::REG_MODE:  predictor_mode <= cfg_data[1:0];
        dpcm_pkg::REG_STEP:  quant_step     <= cfg_data[PW-1:0];
        dpcm_pkg::REG_WIDTH: image_width    <= cfg_data;
        default: ;
      endcase
    end
  end

  // control
  dpcm_pkg::enc_state_t state, state_next;
  logic accept, div_start, div_done, load_out, out_free;

  assign out_free = !results.valid || results.ready;
  assign accept   = pixels.valid && pixels.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      dpcm_pkg::ST_IDLE: if (pixels.valid) state_next = dpcm_pkg::ST_PRED;
      dpcm_pkg::ST_PRED: state_next = dpcm_pkg::ST_DIV;
      dpcm_pkg::ST_DIV:  if (div_done) state_next = dpcm_pkg::ST_DONE;
      dpcm_pkg::ST_DONE: if (out_free) state_next = dpcm_pkg::ST_IDLE;
      default:           state_next = dpcm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pixels.ready = 1'b0;
    div_start    = 1'b0;
    load_out     = 1'b0;
    unique case (state)
      dpcm_pkg::ST_IDLE: pixels.ready = 1'b1;
      dpcm_pkg::ST_PRED: div_start = 1'b1;
      dpcm_pkg::ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpcm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // position tracking
  logic [CW-1:0] col_cnt, col, col_cur;
  logic          first_row, first, first_cur;
  logic [LW-1:0] width_ext, width_eff;
  logic          row_end;

  always_comb begin
    col_cur   = pixels.frame_start ? '0 : col_cnt;
    first_cur = pixels.frame_start || first_row;
    width_ext = LW'(image_width);
    if (width_ext == '0) begin
      width_eff = LW'(1);
    end else if (width_ext > LW'(MAX_WIDTH)) begin
      width_eff = LW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    row_end = (LW'(col) + LW'(1)) >= width_eff;
  end

  // datapath
  logic [PW-1:0]       pix, up, left_pixel, upleft_pixel;
  logic [PW-1:0]       nb_a, nb_b, nb_c;
  dpcm_pkg::pred_res_t pres, pres_q;
  logic [PW-1:0]       rem;
  logic [PW-1:0]       mag;
  logic signed [8:0]   e9;
  logic signed [9:0]   e10, r10, s10, q10;
  logic signed [10:0]  x11, xr11;
  logic signed [9:0]   d10;
  logic [PW-1:0]       d8, recon;

  always_ff @(posedge clk) begin
    if (accept) begin
      pix   <= pixels.pixel;
      col   <= col_cur;
      first <= first_cur;
    end
    if (div_start) begin
      pres_q <= pres;
    end
  end

  dpcm_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .rd_data (up),
    .wr_en   (load_out),
    .wr_addr (col),
    .wr_data (recon)
  );

  always_comb begin
    nb_a = (col != '0) ? left_pixel : dpcm_pkg::MID_GREY;
    nb_c = first ? dpcm_pkg::MID_GREY : up;
    nb_b = (first || col == '0) ? dpcm_pkg::MID_GREY : upleft_pixel;
  end

  dpcm_predictor u_pred (
    .pixel (pix),
    .a     (nb_a),
    .b     (nb_b),
    .c     (nb_c),
    .mode  (predictor_mode),
    .res   (pres)
  );

  // |e| goes to the serial unit; e itself comes straight from the biased byte
  always_comb begin
    e9  = $signed({{2{~pres.biased[PW-1]}}, pres.biased[PW-2:0]});
    mag = e9[8] ? PW'(-e9) : PW'(e9);
  end

  dpcm_rem_serial u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (quant_step),
    .done     (div_done),
    .rem      (rem)
  );

  // trunc(e/s)*s = e - rem for e >= 0 and e + rem for e < 0
  always_comb begin
    e10 = $signed({{3{~pres_q.biased[PW-1]}}, pres_q.biased[PW-2:0]});
    r10 = $signed({2'b00, rem});
    s10 = $signed({2'b00, quant_step});
    if (quant_step == '0) begin
      q10 = e10;
    end else if (e10 > 10'sd0) begin
      q10 = e10 - r10 + s10;
    end else begin
      q10 = e10 + r10;
    end
    x11  = $signed({q10, 1'b0}) - $signed({3'b000, quant_step});
    // halve toward zero
    xr11 = x11 + $signed({10'b0, x11[10]});
    d10  = 10'(xr11 >>> 1);
    d8   = (quant_step == '0) ? e10[PW-1:0] : d10[PW-1:0];
    recon = pres_q.pred + d8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel   <= dpcm_pkg::MID_GREY;
      upleft_pixel <= dpcm_pkg::MID_GREY;
      col_cnt      <= '0;
      first_row    <= 1'b1;
    end else if (load_out) begin
      left_pixel   <= recon;
      upleft_pixel <= up;
      if (row_end) begin
        col_cnt   <= '0;
        first_row <= 1'b0;
      end else begin
        col_cnt   <= col + 1'b1;
        first_row <= first;
      end
    end else if (accept && pixels.frame_start) begin
      col_cnt   <= '0;
      first_row <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (load_out) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      results.biased_error   <= pres_q.biased;
      results.code           <= q10[PW-1:0];
      results.recon_pixel    <= recon;
      results.predictor_used <= pres_q.sel;
    end
  end

  // checks
  a_accept_to_pred: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == dpcm_pkg::ST_PRED)
    else $error("accepted word did not enter prediction");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == dpcm_pkg::ST_DIV)
    else $error("remainder unit finished outside divide state");

  a_writeback: assert property (@(posedge clk) disable iff (rst)
    load_out |=> results.valid && state == dpcm_pkg::ST_IDLE)
    else $error("write-back did not present a result word");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    LW'(col_cnt) < LW'(MAX_WIDTH))
    else $error("column count beyond line store depth");

endmodule

`default_nettype wire
